### design/masked_byte_pattern_search_macros.svh
// ---------------------------------------------------------------------------
// masked byte pattern search assertion macros
// clocked assertion helpers; they expand to nothing for synthesis
// ---------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define MBPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define MBPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MBPS_ASSERT(label, clk, rst, prop, msg)
`define MBPS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/mbps_pkg.sv
// ---------------------------------------------------------------------------
// mbps_pkg
// shared types and constants of the masked byte pattern search
// ---------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

   // register port geometry: four 64-bit registers at 8-byte strides
   localparam int CFG_DATA_W   = 64;
   localparam int CFG_ADDR_W   = 5;
   localparam int CARE_BITS    = 16;
   localparam int LENGTH_W     = 5;
   localparam int OFFSET_OUT_W = 32;

   // register index, taken from paddr above the byte lane bits
   typedef enum logic [1:0] {
      CFG_PATTERN_LOW    = 2'd0,
      CFG_PATTERN_HIGH   = 2'd1,
      CFG_CARE_MASK      = 2'd2,
      CFG_PATTERN_LENGTH = 2'd3
   } cfg_index_type;

   // register contents handed to the search datapath
   typedef struct packed {
      logic [CFG_DATA_W-1:0] pattern_low;
      logic [CFG_DATA_W-1:0] pattern_high;
      logic [CARE_BITS-1:0]  care_mask;
      logic [LENGTH_W-1:0]   pattern_length;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pattern_low:    '0,
      pattern_high:   '0,
      care_mask:      '1,
      pattern_length: LENGTH_W'(1)
   };

endpackage

`default_nettype wire

### design/mbps_if.sv
// ---------------------------------------------------------------------------
// mbps stream interfaces
// valid/ready channels for region bytes in and search results out
// ---------------------------------------------------------------------------
`default_nettype none

// region byte channel
interface mbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// search result channel
interface mbps_rsp_if import mbps_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [OFFSET_OUT_W-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

### design/mbps_csr.sv
// ---------------------------------------------------------------------------
// mbps_csr
// register block: pattern, care mask and length behind an apb-style port
// ---------------------------------------------------------------------------
`default_nettype none

module mbps_csr
   import mbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CFG_ADDR_W-1:0] paddr,
   input  wire logic [CFG_DATA_W-1:0] pwdata,
   output logic      [CFG_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   cfg_index_type index;
   logic          wr_en;

   // byte lane bits are ignored, index sits above them
   assign index  = cfg_index_type'(paddr[CFG_ADDR_W-1:3]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CFG_PATTERN_LOW:    cfg_in.pattern_low    = pwdata;
            CFG_PATTERN_HIGH:   cfg_in.pattern_high   = pwdata;
            CFG_CARE_MASK:      cfg_in.care_mask      = pwdata[CARE_BITS-1:0];
            CFG_PATTERN_LENGTH: cfg_in.pattern_length = pwdata[LENGTH_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         CFG_PATTERN_LOW:    prdata = cfg_ff.pattern_low;
         CFG_PATTERN_HIGH:   prdata = cfg_ff.pattern_high;
         CFG_CARE_MASK:      prdata = CFG_DATA_W'(cfg_ff.care_mask);
         CFG_PATTERN_LENGTH: prdata = CFG_DATA_W'(cfg_ff.pattern_length);
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### design/masked_byte_pattern_search.sv
// flow: an accepted byte is held in the input register and compared there; its result word,
//    if any, is registered in the result register when the byte advances
// throughput: one byte per cycle while the result word is not stalled, set by the parallel window compare
// a stalled result word holds the compare stage; a held compare stage stalls the input
// reset (synchronous, active high) clears the window, byte count, match flag and
//    both stages, and restores the register reset values
// ---------------------------------------------------------------------------
// masked_byte_pattern_search
// finds the first offset of a masked byte pattern in a streamed region
// ---------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_search_macros.svh"

module masked_byte_pattern_search
   import mbps_pkg::*;
#(
   parameter int PATTERN_BYTES = 16,
   parameter int OFFSET_BITS   = 32
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mbps_req_if.sink                   req,
   mbps_rsp_if.source                 rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CFG_ADDR_W-1:0] paddr,
   input  wire logic [CFG_DATA_W-1:0] pwdata,
   output logic      [CFG_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int LEN_W   = $clog2(PATTERN_BYTES + 1);
   localparam int IDX_W   = $clog2(PATTERN_BYTES);
   localparam int CMP_W   = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
   localparam int CMP_POS = (PATTERN_BYTES < CARE_BITS) ? PATTERN_BYTES : CARE_BITS;

   cfg_type cfg;

   mbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp.valid || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last;
      end
   end

   // scan state
   logic [7:0]             window_ff [PATTERN_BYTES-1];
   logic [7:0]             window_in [PATTERN_BYTES-1];
   logic [OFFSET_BITS-1:0] bytes_seen_ff;
   logic [OFFSET_BITS-1:0] bytes_seen_in;
   logic                   match_done_ff;
   logic                   match_done_in;

   // effective length: zero acts as one, clamp at the window size
   logic [CMP_W-1:0] len_raw;
   logic [LEN_W-1:0] len_eff;

   assign len_raw = CMP_W'(cfg.pattern_length);

   always_comb begin
      if (len_raw == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_raw > CMP_W'(PATTERN_BYTES)) begin
         len_eff = LEN_W'(PATTERN_BYTES);
      end else begin
         len_eff = LEN_W'(len_raw);
      end
   end

   // saturating count including the current byte
   logic [OFFSET_BITS-1:0] count;

   assign count = (bytes_seen_ff == '1) ? bytes_seen_ff : bytes_seen_ff + 1'b1;

   // newest byte first: current byte, then the window
   logic [7:0] ext [PATTERN_BYTES];

   always_comb begin
      ext[0] = in_byte_ff;
      for (int k = 1; k < PATTERN_BYTES; k++) begin
         ext[k] = window_ff[k-1];
      end
   end

   // parallel masked compare over the positions that carry a care bit
   logic [2*CFG_DATA_W-1:0] pattern_all;
   logic [CMP_POS-1:0]      pos_ok;

   assign pattern_all = {cfg.pattern_high, cfg.pattern_low};

   always_comb begin
      logic [LEN_W-1:0] age;
      logic [7:0]       sel;
      for (int i = 0; i < CMP_POS; i++) begin
         age = len_eff - LEN_W'(1) - LEN_W'(i);
         if (age < LEN_W'(PATTERN_BYTES)) begin
            sel = ext[age[IDX_W-1:0]];
         end else begin
            sel = '0;
         end
         pos_ok[i] = (LEN_W'(i) >= len_eff) || !cfg.care_mask[i]
                     || (sel == pattern_all[8*i +: 8]);
      end
   end

   logic                   hit;
   logic                   emit_hit;
   logic                   emit_end;
   logic [OFFSET_BITS-1:0] offset_full;
   logic [OFFSET_OUT_W-1:0] offset_out;

   assign hit         = (count >= OFFSET_BITS'(len_eff)) && (&pos_ok);
   assign emit_hit    = hit && !match_done_ff;
   assign emit_end    = in_last_ff && !match_done_ff && !hit;
   assign offset_full = count - OFFSET_BITS'(len_eff);

   // fit the offset to the result field
   generate
      if (OFFSET_BITS >= OFFSET_OUT_W) begin : g_offset_trunc
         assign offset_out = offset_full[OFFSET_OUT_W-1:0];
      end else begin : g_offset_ext
         assign offset_out = {{(OFFSET_OUT_W-OFFSET_BITS){1'b0}}, offset_full};
      end
   endgenerate

   // state update: each byte shifts the window and counts, the last byte clears the scan
   always_comb begin
      window_in     = window_ff;
      bytes_seen_in = bytes_seen_ff;
      match_done_in = match_done_ff;
      if (advance) begin
         if (in_last_ff) begin
            for (int k = 0; k < PATTERN_BYTES - 1; k++) begin
               window_in[k] = '0;
            end
            bytes_seen_in = '0;
            match_done_in = 1'b0;
         end else begin
            window_in[0] = in_byte_ff;
            for (int k = 1; k < PATTERN_BYTES - 1; k++) begin
               window_in[k] = window_ff[k-1];
            end
            bytes_seen_in = count;
            match_done_in = match_done_ff || emit_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_BYTES - 1; k++) begin
            window_ff[k] <= '0;
         end
         bytes_seen_ff <= '0;
         match_done_ff <= 1'b0;
      end else begin
         window_ff     <= window_in;
         bytes_seen_ff <= bytes_seen_in;
         match_done_ff <= match_done_in;
      end
   end

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_found_ff;
   logic [OFFSET_OUT_W-1:0] rsp_offset_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit_hit || emit_end;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (emit_hit || emit_end)) begin
         rsp_found_ff  <= emit_hit;
         rsp_offset_ff <= emit_hit ? offset_out : '0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.match_offset = rsp_offset_ff;

   // checks
   `MBPS_ASSERT(a_ready_only_stalls_full, clock, reset, !req.ready |-> in_valid_ff, "input stalled while empty")
   `MBPS_ASSERT(a_last_clears_scan, clock, reset, (advance && in_last_ff) |=> (bytes_seen_ff == '0 && !match_done_ff), "last byte did not clear scan state")
   `MBPS_ASSERT(a_hit_sets_done, clock, reset, (advance && emit_hit && !in_last_ff) |=> match_done_ff, "reported match not remembered")
   `MBPS_ASSERT(a_result_from_advance, clock, reset, $rose(rsp_valid_ff) |-> $past(advance), "result word without a compared byte")
   `MBPS_ASSERT(a_count_grows, clock, reset, (advance && !in_last_ff) |=> (bytes_seen_ff != '0), "byte count lost after a byte")

endmodule

`default_nettype wire

### tb/sv/mbps_search_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbps_search_checker
// watches the register port and both word channels of the pattern search,
// predicts each search result from its own copy of the registers and scan
// state, and compares every result word with the oldest prediction
// ---------------------------------------------------------------------------

module mbps_search_checker
   import mbps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mbps_req_if                   req_mon,
   mbps_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CFG_ADDR_W-1:0] paddr,
   input  logic [CFG_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int WINDOW_BYTES = 16;

   typedef struct packed {
      logic                    found;
      logic [OFFSET_OUT_W-1:0] match_offset;
   } search_hit_type;

   // register copy and scan state
   cfg_type     regs;
   logic [7:0]  history [0:WINDOW_BYTES-2];
   logic [31:0] bytes_taken;
   bit          region_matched;

   search_hit_type predicted_hits [$];
   search_hit_type oldest;
   int             fail_total = 0;

   task automatic flag_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      fail_total++;
   endtask

   function automatic logic [7:0] pattern_byte(input int pos);
      if (pos < 8) return regs.pattern_low[8*pos +: 8];
      return regs.pattern_high[8*(pos-8) +: 8];
   endfunction

   task automatic clear_region();
      for (int i = 0; i < WINDOW_BYTES-1; i++) history[i] = 8'h00;
      bytes_taken    = '0;
      region_matched = 1'b0;
   endtask

   // one region byte: window compare, then shift or clear
   task automatic scan_byte(input logic [7:0] cur, input logic is_last);
      int          span;
      int          age;
      logic [31:0] count;
      logic [7:0]  seen;
      bit          hit;
      span = int'(regs.pattern_length);
      if (span == 0) span = 1;
      if (span > WINDOW_BYTES) span = WINDOW_BYTES;
      count = (bytes_taken == 32'hFFFF_FFFF) ? bytes_taken : bytes_taken + 32'd1;
      hit = (count >= 32'(span));
      for (int i = 0; i < span && hit; i++) begin
         age  = span - 1 - i;
         seen = (age == 0) ? cur : history[age-1];
         if (regs.care_mask[i] && seen != pattern_byte(i)) hit = 1'b0;
      end
      if (hit && !region_matched) begin
         predicted_hits.push_back('{found: 1'b1, match_offset: count - 32'(span)});
         region_matched = 1'b1;
      end else if (is_last && !region_matched) begin
         predicted_hits.push_back('{found: 1'b0, match_offset: '0});
      end
      if (is_last) begin
         clear_region();
      end else begin
         for (int i = WINDOW_BYTES-2; i > 0; i--) history[i] = history[i-1];
         history[0]  = cur;
         bytes_taken = count;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs = CFG_RESET;
         clear_region();
         predicted_hits.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (cfg_index_type'(paddr[CFG_ADDR_W-1:3]))
               CFG_PATTERN_LOW:    regs.pattern_low    = pwdata;
               CFG_PATTERN_HIGH:   regs.pattern_high   = pwdata;
               CFG_CARE_MASK:      regs.care_mask      = pwdata[CARE_BITS-1:0];
               CFG_PATTERN_LENGTH: regs.pattern_length = pwdata[LENGTH_W-1:0];
               default: ;
            endcase
         end
         // accepted region byte
         if (req_mon.valid && req_mon.ready) scan_byte(req_mon.data_byte, req_mon.last);
         // accepted result word
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_hits.size() == 0) begin
               flag_mismatch($sformatf("result word with none pending: found=%0b offset=%0d",
                                       rsp_mon.found, rsp_mon.match_offset));
            end else begin
               oldest = predicted_hits.pop_front();
               if (rsp_mon.found !== oldest.found)
                  flag_mismatch($sformatf("found %b, predicted %b",
                                          rsp_mon.found, oldest.found));
               if (rsp_mon.match_offset !== oldest.match_offset)
                  flag_mismatch($sformatf("match_offset %0d, predicted %0d",
                                          rsp_mon.match_offset, oldest.match_offset));
            end
         end
      end
      mismatches  <= fail_total;
      outstanding <= predicted_hits.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// stimulus for the masked byte pattern search: directed regions for the
// corner cases, then random pattern settings and regions with planted,
// broken and near-miss patterns, random idling on both word channels
// ---------------------------------------------------------------------------

module tb
   import mbps_pkg::*;
;

   localparam int TARGET_BYTES   = 1500;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TAIL_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CFG_ADDR_W-1:0] paddr   = '0;
   logic [CFG_DATA_W-1:0] pwdata  = '0;
   logic [CFG_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatches;
   int outstanding;
   int items_sent   = 0;
   int ready_left   = 0;
   int quiet_cycles = 0;

   // what the stimulus knows of the current setting, for planting patterns
   logic [7:0]  gen_pat [0:15];
   logic [15:0] gen_care = 16'hFFFF;
   int          gen_len  = 1;

   mbps_req_if req_bus ();
   mbps_rsp_if rsp_bus ();

   masked_byte_pattern_search dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   mbps_search_checker search_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   // gap length: mostly none or short, a few long
   function automatic int idle_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_left = idle_gap(1'b0);
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_left = $urandom_range(0, 40);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one region byte, after an optional gap
   task automatic push_byte(input logic [7:0] data, input logic is_last, input bit quiet);
      int gap;
      gap = idle_gap(quiet);
      if (gap > 0) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= 8'($urandom);
         req_bus.last      <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.last      <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // stop sending and let every pending result word out
   task automatic drain_search();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write: setup phase, access phase until pready, then idle
   task automatic program_register(input cfg_index_type idx, input logic [63:0] value);
      int raw;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CFG_ADDR_W'({idx, 3'b000});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         CFG_PATTERN_LOW:  for (int j = 0; j < 8; j++) gen_pat[j] = value[8*j +: 8];
         CFG_PATTERN_HIGH: for (int j = 0; j < 8; j++) gen_pat[j+8] = value[8*j +: 8];
         CFG_CARE_MASK:    gen_care = value[15:0];
         CFG_PATTERN_LENGTH: begin
            raw = int'(value[4:0]);
            gen_len = (raw == 0) ? 1 : (raw > 16) ? 16 : raw;
         end
         default: ;
      endcase
   endtask

   function automatic logic [63:0] pattern_word();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll == 2) return {8{8'h78}};
      return {$urandom, $urandom};
   endfunction

   // new pattern setting, all registers or a random subset
   task automatic pick_config(input bit all);
      logic [63:0] word;
      int          roll;
      if (all || $urandom_range(0, 1)) program_register(CFG_PATTERN_LOW, pattern_word());
      if (all || $urandom_range(0, 1)) program_register(CFG_PATTERN_HIGH, pattern_word());
      if (all || $urandom_range(0, 1)) begin
         word = {$urandom, $urandom};
         roll = $urandom_range(0, 7);
         if (roll == 0) word[15:0] = 16'h0000;
         else if (roll < 3) word[15:0] = 16'hFFFF;
         else if (roll == 3) word[15:0] = 16'h0001 << $urandom_range(0, 15);
         program_register(CFG_CARE_MASK, word);
      end
      if (all || $urandom_range(0, 1)) begin
         word = {$urandom, $urandom};
         roll = $urandom_range(0, 9);
         case (roll)
            0:       word[4:0] = 5'd0;
            1:       word[4:0] = 5'($urandom_range(17, 31));
            2:       word[4:0] = 5'd16;
            default: word[4:0] = 5'($urandom_range(1, 16));
         endcase
         program_register(CFG_PATTERN_LENGTH, word);
      end
   endtask

   // one region: random, pattern-alphabet or planted (sometimes broken) content
   task automatic scan_region();
      logic [7:0] region_bytes [0:127];
      int         span;
      int         mode;
      int         at;
      int         pick;
      bit         quiet;
      span = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 128);
      mode = $urandom_range(0, 9);
      for (int i = 0; i < span; i++) begin
         if (mode >= 2 && $urandom_range(0, 3) != 0)
            region_bytes[i] = gen_pat[$urandom_range(0, 15)];
         else
            region_bytes[i] = 8'($urandom);
      end
      if (mode >= 4 && span >= gen_len) begin
         at = $urandom_range(0, span - gen_len);
         for (int j = 0; j < gen_len; j++)
            if (gen_care[j]) region_bytes[at+j] = gen_pat[j];
         if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, gen_len - 1);
            region_bytes[at+pick] = region_bytes[at+pick] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < span; i++) push_byte(region_bytes[i], i == span - 1, quiet);
   endtask

   initial begin : stimulus
      for (int j = 0; j < 16; j++) gen_pat[j] = 8'h00;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: one byte pattern 8'h00
      push_byte(8'hFF, 1'b0, 1'b0);   // match on the last byte, offset 1
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);   // first hit reported, later hit and last silent
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b0);   // no match in region
      drain_search();

      // length zero acts as one
      program_register(CFG_PATTERN_LOW, {{7{8'hA5}}, 8'h78});
      program_register(CFG_PATTERN_LENGTH, 64'h0);
      push_byte(8'h78, 1'b1, 1'b0);
      drain_search();

      // region shorter than the pattern
      program_register(CFG_PATTERN_LOW, {8{8'h78}});
      program_register(CFG_PATTERN_LENGTH, 64'd3);
      push_byte(8'h78, 1'b0, 1'b0);
      push_byte(8'h78, 1'b1, 1'b0);
      drain_search();

      // oversized length acts as 16, nothing cared: match completes on last byte
      program_register(CFG_CARE_MASK, 64'hFFFF_FFFF_FFFF_0000);
      program_register(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
      for (int i = 0; i < 16; i++) push_byte(i[0] ? 8'hFF : 8'h00, i == 15, 1'b0);
      drain_search();

      // random settings and regions
      pick_config(1'b1);
      while (items_sent < TARGET_BYTES) begin
         repeat ($urandom_range(3, 8)) scan_region();
         drain_search();
         pick_config(1'b0);
      end

      drain_search();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
